### rtl/dnsld_pkg.sv
// ----------------------------------------------------------------------------
// dnsld_pkg
// Types and constants shared by the DNS name label decoder modules.
// ----------------------------------------------------------------------------
package dnsld_pkg;

   localparam int unsigned CAP_W        = 8;   // output_capacity register width
   localparam int unsigned COUNT_W      = 7;   // output character count
   localparam int unsigned POS_W        = 8;   // input byte position
   localparam int unsigned LABEL_W      = 6;   // label length / label count

   localparam logic [CAP_W-1:0]   CAP_RESET     = 8'd128;
   localparam logic [LABEL_W-1:0] MAX_LABELS    = 6'd32;
   localparam logic [POS_W-1:0]   POS_LIMIT     = 8'd253;
   localparam logic [POS_W-1:0]   POS_SAT       = 8'd255;
   localparam logic [7:0]         MAX_LABEL_LEN = 8'd63;
   localparam logic [7:0]         DOT_CHAR      = 8'h2E;

   // register word index decoded from the csr address
   localparam logic REG_OUTPUT_CAPACITY = 1'b0;

   // result queue
   localparam int unsigned FIFO_DEPTH = 4;
   localparam int unsigned FIFO_PTR_W = 2;
   localparam int unsigned FIFO_LVL_W = 3;

   typedef struct packed {
      logic [COUNT_W-1:0] name_length;
      logic               is_end;
      logic [7:0]         out_char;
   } result_type;

   // up to two results pushed per accepted request, in order ent0 then ent1
   typedef struct packed {
      logic [1:0] n;
      result_type ent1;
      result_type ent0;
   } push_type;

   typedef struct packed {
      logic                  room2;
      logic [FIFO_LVL_W-1:0] level;
   } fifo_status_type;

endpackage

### rtl/dnsld_fifo.sv
// ----------------------------------------------------------------------------
// dnsld_fifo
// Small result queue: up to two results in per cycle, one out per ready cycle.
// ----------------------------------------------------------------------------
module dnsld_fifo (
   input  logic                       clock,
   input  logic                       reset,
   input  dnsld_pkg::push_type        push,
   output dnsld_pkg::fifo_status_type status,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output dnsld_pkg::result_type      rsp_data
);

   dnsld_pkg::result_type mem [dnsld_pkg::FIFO_DEPTH];

   logic [dnsld_pkg::FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [dnsld_pkg::FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [dnsld_pkg::FIFO_LVL_W-1:0] level_ff, level_in;
   logic                             pop;
   logic [dnsld_pkg::FIFO_PTR_W-1:0] wr_ptr_nxt;

   assign pop        = rsp_tvalid && rsp_tready;
   assign wr_ptr_nxt = wr_ptr_ff + dnsld_pkg::FIFO_PTR_W'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + dnsld_pkg::FIFO_PTR_W'(push.n);
      rd_ptr_in = rd_ptr_ff + dnsld_pkg::FIFO_PTR_W'(pop);
      level_in  = level_ff + dnsld_pkg::FIFO_LVL_W'(push.n)
                  - dnsld_pkg::FIFO_LVL_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.n != 2'd0) begin
         mem[wr_ptr_ff] <= push.ent0;
      end
      if (push.n == 2'd2) begin
         mem[wr_ptr_nxt] <= push.ent1;
      end
   end

   assign rsp_data     = mem[rd_ptr_ff];
   assign rsp_tvalid   = (level_ff != '0);
   assign status.level = level_ff;
   assign status.room2 = (level_ff <= dnsld_pkg::FIFO_LVL_W'(dnsld_pkg::FIFO_DEPTH - 2));

endmodule

### rtl/dns_name_label_decoder.sv
// ----------------------------------------------------------------------------
// dns_name_label_decoder
// Streams wire-format DNS name bytes in, dotted name characters out.
// ----------------------------------------------------------------------------
// One wire-format byte is taken per request, one request per clock cycle while
// req_tready is high. The decode state is updated when the request is accepted
// and its results (none, a character and/or the end result) go to a four-entry
// result queue; rsp_tvalid rises the cycle after a push into an empty queue.
// The output side moves one result per cycle while rsp_tready is high, so a
// character plus end result needs an extra output transfer; req_tready stays
// high while the queue has room for two results, which holds back-to-back
// under a ready sink. A name starts at a req_tuser (first) byte and stops at
// a zero or >63 length byte, after 32 labels, at input position 253 or more at
// a label end, at req_tlast, or at min(output_capacity, MAX_NAME, 128)-1
// characters emitted; later bytes are dropped until the next first byte.
// ----------------------------------------------------------------------------
module dns_name_label_decoder #(
   parameter int unsigned MAX_NAME = 128   // name buffer bound, 16..256
) (
   input  logic        clock,
   input  logic        reset,

   // request: wire-format byte
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] payload_byte
   input  logic        req_tuser,    // [0] first_byte
   input  logic        req_tlast,    // last_byte

   // result: decoded character or end marker
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,    // [7:0] out_char, [14:8] name_length, [15] zero
   output logic        rsp_tlast,    // is_end

   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // effective buffer size never exceeds 128 (7-bit count)
   localparam int unsigned CAP_MAX = (MAX_NAME < 128) ? MAX_NAME : 128;
   localparam logic [dnsld_pkg::CAP_W-1:0] CAP_MAX_V = dnsld_pkg::CAP_W'(CAP_MAX);

   // ------------------------------------------------------------------------
   // Config register
   // ------------------------------------------------------------------------
   logic [dnsld_pkg::CAP_W-1:0] capacity_ff;
   logic                        csr_write;
   logic                        csr_hit;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[2] == dnsld_pkg::REG_OUTPUT_CAPACITY);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= dnsld_pkg::CAP_RESET;
      end else if (csr_write && csr_hit) begin
         capacity_ff <= csr_pwdata[dnsld_pkg::CAP_W-1:0];
      end
   end

   assign csr_prdata = csr_hit ? {24'd0, capacity_ff} : 32'd0;

   // limit = min(capacity, MAX_NAME, 128) - 1, zero for capacity zero
   logic [dnsld_pkg::CAP_W-1:0]   cap_eff;
   logic [dnsld_pkg::COUNT_W-1:0] limit;

   always_comb begin
      cap_eff = (capacity_ff > CAP_MAX_V) ? CAP_MAX_V : capacity_ff;
      limit   = (cap_eff == '0) ? '0
                : dnsld_pkg::COUNT_W'(cap_eff - dnsld_pkg::CAP_W'(1));
   end

   // ------------------------------------------------------------------------
   // Decode state
   // ------------------------------------------------------------------------
   logic                            stopped_ff,   stopped_in;
   logic                            in_label_ff,  in_label_in;
   logic [dnsld_pkg::LABEL_W-1:0]   remain_ff,    remain_in;
   logic [dnsld_pkg::POS_W-1:0]     position_ff,  position_in;
   logic [dnsld_pkg::COUNT_W-1:0]   count_ff,     count_in;
   logic [dnsld_pkg::LABEL_W-1:0]   labels_ff,    labels_in;

   logic                            req_fire;
   logic                            emit_char;
   logic                            emit_end;
   logic                            done;        // stopped before the final checks
   logic [7:0]                      char_val;
   logic [dnsld_pkg::POS_W-1:0]     pos_bump;
   logic [dnsld_pkg::LABEL_W-1:0]   remain_dec;

   dnsld_pkg::push_type        push;
   dnsld_pkg::fifo_status_type fifo_status;
   dnsld_pkg::result_type      char_res;
   dnsld_pkg::result_type      end_res;
   dnsld_pkg::result_type      rsp_data;

   assign req_tready = fifo_status.room2;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      // first byte clears the name state before anything else
      stopped_in  = req_tuser ? 1'b0 : stopped_ff;
      in_label_in = req_tuser ? 1'b0 : in_label_ff;
      remain_in   = req_tuser ? '0   : remain_ff;
      position_in = req_tuser ? '0   : position_ff;
      count_in    = req_tuser ? '0   : count_ff;
      labels_in   = req_tuser ? '0   : labels_ff;

      emit_char = 1'b0;
      emit_end  = 1'b0;
      done      = 1'b0;
      char_val  = req_tdata;

      pos_bump   = (position_in == dnsld_pkg::POS_SAT) ? position_in
                   : position_in + dnsld_pkg::POS_W'(1);
      remain_dec = remain_in - dnsld_pkg::LABEL_W'(1);

      if (stopped_in) begin
         done = 1'b1;                       // idle: drop byte
      end else if (count_in >= limit) begin
         emit_end   = 1'b1;                 // buffer already full
         done       = 1'b1;
         stopped_in = 1'b1;
      end else if (!in_label_in) begin
         if (req_tdata == 8'd0 || req_tdata > dnsld_pkg::MAX_LABEL_LEN) begin
            emit_end   = 1'b1;              // root label or bad length
            done       = 1'b1;
            stopped_in = 1'b1;
         end else begin
            labels_in   = labels_in + dnsld_pkg::LABEL_W'(1);
            position_in = pos_bump;
            in_label_in = 1'b1;
            remain_in   = req_tdata[dnsld_pkg::LABEL_W-1:0];
            if (count_in != '0) begin
               emit_char = 1'b1;            // separator before later labels
               char_val  = dnsld_pkg::DOT_CHAR;
               count_in  = count_in + dnsld_pkg::COUNT_W'(1);
            end
         end
      end else begin
         emit_char   = 1'b1;                // label byte passes through
         count_in    = count_in + dnsld_pkg::COUNT_W'(1);
         position_in = pos_bump;
         remain_in   = remain_dec;
         if (remain_dec == '0) begin
            in_label_in = 1'b0;
         end
      end

      if (!done && (req_tlast || count_in >= limit ||
                    (!in_label_in && (labels_in >= dnsld_pkg::MAX_LABELS ||
                                      position_in >= dnsld_pkg::POS_LIMIT)))) begin
         emit_end   = 1'b1;
         stopped_in = 1'b1;
      end

      char_res.out_char    = char_val;
      char_res.is_end      = 1'b0;
      char_res.name_length = '0;
      end_res.out_char     = 8'd0;
      end_res.is_end       = 1'b1;
      end_res.name_length  = count_in;

      // results in order: character first, end result after it
      push.ent0 = emit_char ? char_res : end_res;
      push.ent1 = end_res;
      push.n    = req_fire ? (2'(emit_char) + 2'(emit_end)) : 2'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stopped_ff  <= 1'b1;
         in_label_ff <= 1'b0;
         remain_ff   <= '0;
         position_ff <= '0;
         count_ff    <= '0;
         labels_ff   <= '0;
      end else if (req_fire) begin
         stopped_ff  <= stopped_in;
         in_label_ff <= in_label_in;
         remain_ff   <= remain_in;
         position_ff <= position_in;
         count_ff    <= count_in;
         labels_ff   <= labels_in;
      end
   end

   // ------------------------------------------------------------------------
   // Result queue
   // ------------------------------------------------------------------------
   dnsld_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .status     (fifo_status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_data   (rsp_data)
   );

   assign rsp_tdata = {1'b0, rsp_data.name_length, rsp_data.out_char};
   assign rsp_tlast = rsp_data.is_end;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   a_end_stops: assert property (@(posedge clock) disable iff (reset)
      (req_fire && emit_end) |=> stopped_ff)
      else $error("end result pushed but decoder not stopped");

   a_label_remain: assert property (@(posedge clock) disable iff (reset)
      in_label_ff |-> (remain_ff != '0))
      else $error("inside a label with no bytes left");

   a_idle_silent: assert property (@(posedge clock) disable iff (reset)
      (req_fire && stopped_ff && !req_tuser) |-> (push.n == 2'd0))
      else $error("result produced while stopped");

   a_fifo_bound: assert property (@(posedge clock) disable iff (reset)
      fifo_status.level <= dnsld_pkg::FIFO_LVL_W'(dnsld_pkg::FIFO_DEPTH))
      else $error("result queue overflow");

endmodule

### test/dns_name_label_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dns_name_label_decoder_tb
// Self-checking bench: wire-format name bytes in, dotted characters checked.
// ----------------------------------------------------------------------------
// Each accepted request is decoded by an in-bench model of the label decoder
// and its characters and end marker are queued; every response is compared
// field by field with the oldest queued entry. Directed cases come first,
// then capacity edges, a capacity drop in the middle of a name, the label
// count stop, a long sink hold-off and a long random run of mostly
// well-formed names with noise, bad lengths and truncations mixed in.
// ----------------------------------------------------------------------------
module dns_name_label_decoder_tb;

   localparam int unsigned NAME_BOUND    = 128;
   localparam int unsigned CYCLE_LIMIT   = 1_000_000;
   localparam int unsigned HOLD_CYCLES   = 400;
   localparam int unsigned ITEM_TARGET   = 1200;
   localparam int unsigned PHASE_ITEMS   = 120;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned DRAIN_LIMIT   = 20_000;
   localparam logic [2:0]  CAP_ADDR      = {dnsld_pkg::REG_OUTPUT_CAPACITY, 2'b00};

   // ------------------------------------------------------------------------
   // DUT ports, all inputs known from time zero
   // ------------------------------------------------------------------------
   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata   = 8'h00;   // [7:0] payload_byte
   logic        req_tuser   = 1'b0;    // [0] first_byte
   logic        req_tlast   = 1'b0;    // last_byte
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [15:0] rsp_tdata;             // [7:0] out_char, [14:8] name_length, [15] zero
   logic        rsp_tlast;             // is_end
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = 3'd0;
   logic [31:0] csr_pwdata  = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   dns_name_label_decoder #(
      .MAX_NAME    (NAME_BOUND)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // ------------------------------------------------------------------------
   // Bench-side decoder state and the queue of decoded name characters
   // ------------------------------------------------------------------------
   logic [dnsld_pkg::CAP_W-1:0]   cap_reg    = dnsld_pkg::CAP_RESET;
   logic                          in_label_m = 1'b0;
   logic [dnsld_pkg::LABEL_W-1:0] label_left = '0;
   logic [dnsld_pkg::POS_W-1:0]   byte_pos   = '0;
   logic [dnsld_pkg::COUNT_W-1:0] chars_out  = '0;
   logic [dnsld_pkg::LABEL_W-1:0] label_cnt  = '0;
   logic                          name_done  = 1'b1;    // idle until a first byte
   dnsld_pkg::result_type         name_chars_q[$];

   int unsigned errors      = 0;
   int unsigned items_sent  = 0;
   int unsigned cycles      = 0;
   bit          src_gaps    = 1'b0;
   bit          sink_stalls = 1'b0;
   logic        hold_go     = 1'b0;   // toggled by a test to start a hold-off
   logic        hold_seen   = 1'b0;
   int unsigned sink_wait   = 0;

   function automatic void push_char(input logic [7:0] ch, input logic fin,
                                     input logic [dnsld_pkg::COUNT_W-1:0] len);
      dnsld_pkg::result_type r;
      r.out_char    = ch;
      r.is_end      = fin;
      r.name_length = len;
      name_chars_q.push_back(r);
   endfunction

   function automatic void close_name();
      name_done = 1'b1;
      push_char(8'h00, 1'b1, chars_out);
   endfunction

   function automatic void bump_pos();
      if (byte_pos != dnsld_pkg::POS_SAT)
         byte_pos = byte_pos + dnsld_pkg::POS_W'(1);
   endfunction

   // one wire byte through the label state machine
   function automatic void decode_wire_byte(input logic [7:0] b, input logic first,
                                            input logic last);
      int unsigned clamp;
      int unsigned limit;
      clamp = 32'(cap_reg);
      if (clamp > NAME_BOUND) clamp = NAME_BOUND;
      if (clamp > 128) clamp = 128;
      limit = (clamp == 0) ? 0 : clamp - 1;

      if (first) begin
         in_label_m = 1'b0;
         label_left = '0;
         byte_pos   = '0;
         chars_out  = '0;
         label_cnt  = '0;
         name_done  = 1'b0;
      end
      if (name_done) return;

      // buffer already full (capacity lowered or tiny): end without decoding
      if (chars_out >= limit) begin
         close_name();
         return;
      end

      if (!in_label_m) begin
         if (b == 8'd0 || b > dnsld_pkg::MAX_LABEL_LEN) begin
            close_name();
            return;
         end
         label_cnt  = label_cnt + dnsld_pkg::LABEL_W'(1);
         bump_pos();
         in_label_m = 1'b1;
         label_left = b[dnsld_pkg::LABEL_W-1:0];
         if (chars_out > 0) begin
            push_char(dnsld_pkg::DOT_CHAR, 1'b0, '0);
            chars_out = chars_out + dnsld_pkg::COUNT_W'(1);
         end
      end else begin
         push_char(b, 1'b0, '0);
         chars_out  = chars_out + dnsld_pkg::COUNT_W'(1);
         bump_pos();
         label_left = label_left - dnsld_pkg::LABEL_W'(1);
         if (label_left == '0) in_label_m = 1'b0;
      end

      if (last || chars_out >= limit ||
          (!in_label_m && (label_cnt >= dnsld_pkg::MAX_LABELS ||
                           byte_pos >= dnsld_pkg::POS_LIMIT)))
         close_name();
   endfunction

   // ------------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------------
   task automatic report(input string what, input logic [31:0] got,
                         input logic [31:0] want);
      errors++;
      $display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
   endtask

   always @(posedge clock) begin : check_results
      dnsld_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (name_chars_q.size() == 0) begin
            report("response with nothing pending", 32'(rsp_tdata), 32'd0);
         end else begin
            want = name_chars_q.pop_front();
            if (rsp_tdata[7:0] !== want.out_char)
               report("out_char", 32'(rsp_tdata[7:0]), 32'(want.out_char));
            if (rsp_tlast !== want.is_end)
               report("is_end", 32'(rsp_tlast), 32'(want.is_end));
            if (rsp_tdata[14:8] !== want.name_length)
               report("name_length", 32'(rsp_tdata[14:8]), 32'(want.name_length));
            if (rsp_tdata[15] !== 1'b0)
               report("tdata pad bit", 32'(rsp_tdata[15]), 32'd0);
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("[dns_name_label_decoder] ERROR");
         $finish;
      end
   end

   // mostly short idle stretches, now and then a long one
   function automatic int unsigned idle_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // response sink: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         sink_wait  <= 0;
      end else if (hold_go != hold_seen) begin
         hold_seen  <= hold_go;
         sink_wait  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (sink_wait > 0) begin
         sink_wait  <= sink_wait - 1;
         rsp_tready <= 1'b0;
      end else if (sink_stalls && $urandom_range(0, 99) < 15) begin
         sink_wait  <= idle_len() - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------
   // valid stays high after acceptance; the next call either re-drives it or
   // drops it, and settle() drops it before anything else happens
   task automatic send_byte(input logic [7:0] b, input logic first, input logic last);
      int unsigned gap;
      gap = (src_gaps && $urandom_range(0, 99) < 25) ? idle_len() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= first;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      decode_wire_byte(b, first, last);
      items_sent++;
   endtask

   task automatic send_seq(input logic [7:0] seq[$], input logic first_on,
                           input int last_at);
      for (int i = 0; i < seq.size(); i++)
         send_byte(seq[i], first_on && i == 0, i == last_at);
   endtask

   // stop offering, let every pending response out, then let the bench sit quiet
   task automatic settle();
      int unsigned n;
      n = 0;
      req_tvalid <= 1'b0;
      while (name_chars_q.size() != 0 && n < DRAIN_LIMIT) begin
         @(posedge clock);
         n++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write output_capacity, then read it back; only called when idle
   task automatic set_capacity(input logic [7:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CAP_ADDR;
      csr_pwdata  <= {24'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      cap_reg     = value;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== {24'd0, value})
         report("capacity readback", csr_prdata, {24'd0, value});
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // one name: mostly well formed with random label content, sometimes noise,
   // a bad length byte, a truncation or junk after the stop
   task automatic send_random_name();
      logic [7:0]  pkt[$];
      int unsigned r;
      int unsigned nlab;
      int unsigned len;
      int          last_at;
      r = $urandom_range(0, 99);
      if (r < 8) begin
         repeat ($urandom_range(1, 4))
            send_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
         return;
      end
      // long runs of tiny labels can reach the 32-label stop
      nlab = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 36) : $urandom_range(1, 5);
      for (int i = 0; i < nlab; i++) begin
         r = $urandom_range(0, 99);
         if (nlab > 20)   len = $urandom_range(1, 2);
         else if (r < 70) len = $urandom_range(1, 12);
         else if (r < 95) len = $urandom_range(13, 62);
         else             len = 32'(dnsld_pkg::MAX_LABEL_LEN);
         pkt.push_back(8'(len));
         repeat (len) pkt.push_back(8'($urandom_range(0, 255)));
      end
      last_at = -1;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         pkt.push_back(8'd0);
         if ($urandom_range(0, 1)) last_at = pkt.size() - 1;
      end else if (r < 80) begin
         last_at = pkt.size() - 1;
      end else if (r < 92) begin
         pkt.insert($urandom_range(0, pkt.size() - 1), 8'($urandom_range(64, 255)));
      end
      if ($urandom_range(0, 4) == 0)
         repeat ($urandom_range(1, 3)) pkt.push_back(8'($urandom_range(0, 255)));
      send_seq(pkt, 1'b1, last_at);
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   task automatic test_directed();
      src_gaps    = 1'b0;
      sink_stalls = 1'b0;
      send_byte(8'h05, 1'b0, 1'b0);                      // idle: dropped
      // label bytes pass through as is, including 00, FF and a dot byte
      send_seq('{8'h02, 8'h00, 8'hFF, 8'h02, 8'h2E, 8'h80, 8'h00}, 1'b1, -1);
      send_byte(8'h41, 1'b0, 1'b0);                      // after stop: dropped
      send_byte(8'h40, 1'b1, 1'b0);                      // length 64 ends at once
      send_byte(8'hFF, 1'b1, 1'b0);                      // length 255
      send_byte(8'h00, 1'b1, 1'b1);                      // empty name, with last
      send_seq('{8'h05, 8'h61}, 1'b1, 1);                // last inside a label
      send_byte(8'h01, 1'b1, 1'b1);                      // first and last together
      send_seq('{8'h03, 8'h61, 8'h62}, 1'b1, -1);        // cut off by a new first
      send_seq('{8'h01, 8'h7A, 8'h01, 8'h79}, 1'b1, 3);
      settle();
   endtask

   // capacity extremes, the dot landing on the limit, and tiny capacities
   task automatic test_capacity_edges();
      logic [7:0] caps[$];
      caps = '{8'd2, 8'd3, 8'd4, 8'd1, 8'd0, 8'd255, 8'd128};
      sink_stalls = 1'b1;
      foreach (caps[i]) begin
         set_capacity(caps[i]);
         send_seq('{8'h02, 8'h61, 8'h62, 8'h01, 8'h63, 8'h03, 8'h64, 8'h65, 8'h66,
                    8'h00}, 1'b1, -1);
         settle();
      end
   endtask

   // capacity dropped below the count while a name is still open
   task automatic test_lower_mid_name();
      sink_stalls = 1'b0;
      send_seq('{8'h04, 8'h61, 8'h62}, 1'b1, -1);
      settle();
      set_capacity(8'd2);
      send_byte(8'h63, 1'b0, 1'b0);                      // end result, length 2
      send_byte(8'h64, 1'b0, 1'b1);                      // dropped
      settle();
      set_capacity(8'd128);
   endtask

   // 34 one-byte labels: decoding ends after the 32nd
   task automatic test_label_count();
      logic [7:0] pkt[$];
      for (int i = 0; i < 34; i++) begin
         pkt.push_back(8'h01);
         pkt.push_back(8'(8'h41 + i));
      end
      pkt.push_back(8'h00);
      send_seq(pkt, 1'b1, -1);
      settle();
   endtask

   // sink holds off for a long stretch while requests keep coming
   task automatic test_backpressure();
      src_gaps    = 1'b0;
      sink_stalls = 1'b0;
      hold_go    <= ~hold_go;
      repeat (4) send_random_name();
      settle();
   endtask

   task automatic test_random();
      int unsigned start;
      int unsigned phase_start;
      int unsigned r;
      start = items_sent;
      while (items_sent - start < ITEM_TARGET) begin
         r = $urandom_range(0, 99);
         if (r < 15)      set_capacity(8'd128);
         else if (r < 25) set_capacity(8'd2);
         else if (r < 45) set_capacity(8'($urandom_range(3, 12)));
         else if (r < 92) set_capacity(8'($urandom_range(2, 128)));
         else             set_capacity($urandom_range(0, 1) ? 8'd255 : 8'd1);
         src_gaps    = $urandom_range(0, 3) != 0;
         sink_stalls = $urandom_range(0, 3) != 0;
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) send_random_name();
         settle();
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_capacity_edges();
      test_lower_mid_name();
      test_label_count();
      test_backpressure();
      test_random();
      settle();
      if (name_chars_q.size() != 0)
         report("responses never seen", name_chars_q.size(), 32'd0);
      if (errors == 0)
         $display("[dns_name_label_decoder] OK");
      else
         $display("[dns_name_label_decoder] ERROR");
      $finish;
   end

endmodule

### dns_name_label_decoder.f
rtl/dnsld_pkg.sv
rtl/dnsld_fifo.sv
rtl/dns_name_label_decoder.sv
test/dns_name_label_decoder_tb.sv
